// ===== src/pbs_pkg.sv =====
// shared constants and types for the priority budget scheduler
package pbs_pkg;

   localparam int NUM_TASKS_DEF   = 16;
   localparam int NUM_LEVELS_DEF  = 4;
   localparam int BUDGET_BITS_DEF = 8;

   localparam int MODE_W  = 3;
   localparam int ID_W    = 4;
   localparam int LVLIN_W = 2;
   localparam int BUDIN_W = 8;
   localparam int STAT_W  = 2;
   localparam int SCALE_W = 4;
   localparam int BASE_W  = 6;

   localparam logic [MODE_W-1:0] MODE_ADMIT = 3'd0;
   localparam logic [MODE_W-1:0] MODE_YIELD = 3'd1;
   localparam logic [MODE_W-1:0] MODE_BLOCK = 3'd2;
   localparam logic [MODE_W-1:0] MODE_WAKE  = 3'd3;
   localparam logic [MODE_W-1:0] MODE_TICK  = 3'd4;

   localparam logic [STAT_W-1:0] STAT_OK      = 2'd0;
   localparam logic [STAT_W-1:0] STAT_NONE    = 2'd1;
   localparam logic [STAT_W-1:0] STAT_ILLEGAL = 2'd2;

   localparam logic [1:0] ST_FREE    = 2'd0;
   localparam logic [1:0] ST_READY   = 2'd1;
   localparam logic [1:0] ST_RUNNING = 2'd2;
   localparam logic [1:0] ST_WAITING = 2'd3;

   localparam logic [SCALE_W-1:0] CSR_SCALE_RST = 4'd10;
   localparam logic [BASE_W-1:0]  CSR_BASE_RST  = 6'd10;
   localparam logic CSR_IDX_SCALE = 1'b0;
   localparam logic CSR_IDX_BASE  = 1'b1;

endpackage

// ===== src/priority_budget_scheduler_core.sv =====
// priority budget scheduler top level: slot memory, level lists and pick sequencer
//
// usage: one request beat (req_mode, req_task_id, req_task_level, req_task_budget)
// is taken when req_valid is high and req_stall low; it yields exactly one
// response beat (rsp_running_id, rsp_running_valid, rsp_status, rsp_refilled)
// on rsp_valid, held while rsp_stall is high.
// modes: admit, yield, block, wake, tick. yield and block walk the ready lists
// from the highest level down, one slot at a time through the slot memory;
// if nothing with budget is found, one refill pass walks every list and the
// pick runs once more.
// sequencing: a legal admit or wake goes through decode, slot read and append,
// a tick through decode, budget read and budget write, before the response;
// a pick visits each slot with a read and a check, and a yield that puts the
// running task back adds the slot read and append; the slot memory read port
// (one read per step) sets the pace. one item at a time; req_stall stays high
// from acceptance until the response beat has been taken.
// reset: synchronous, all slots free, all lists empty, nothing running,
// budget_scale and budget_base back to 10. slot memory needs no clearing
// since a slot is only read once it has been admitted.
// csr: csr_valid/csr_ready with csr_index, csr_data; write only when idle.
module priority_budget_scheduler_core #(
   parameter int NUM_TASKS   = pbs_pkg::NUM_TASKS_DEF,
   parameter int NUM_LEVELS  = pbs_pkg::NUM_LEVELS_DEF,
   parameter int BUDGET_BITS = pbs_pkg::BUDGET_BITS_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic [pbs_pkg::MODE_W-1:0]  req_mode,
   input  logic [pbs_pkg::ID_W-1:0]    req_task_id,
   input  logic [pbs_pkg::LVLIN_W-1:0] req_task_level,
   input  logic [pbs_pkg::BUDIN_W-1:0] req_task_budget,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [pbs_pkg::ID_W-1:0]    rsp_running_id,
   output logic                        rsp_running_valid,
   output logic [pbs_pkg::STAT_W-1:0]  rsp_status,
   output logic                        rsp_refilled,
   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  logic                        csr_index,
   input  logic [7:0]                  csr_data
);

   localparam int TW = (NUM_TASKS > 1) ? $clog2(NUM_TASKS) : 1;
   localparam int LW = (NUM_LEVELS > 1) ? $clog2(NUM_LEVELS) : 1;
   localparam int BW = BUDGET_BITS;
   localparam int PW = LW + pbs_pkg::SCALE_W;
   localparam int PB = (PW > pbs_pkg::BASE_W) ? PW : pbs_pkg::BASE_W;
   localparam int SW = ((PB > BW) ? PB : BW) + 1;
   localparam logic [BW-1:0] BMAX = {BW{1'b1}};

   // sequencer codes
   localparam logic [3:0] S_IDLE   = 4'd0;
   localparam logic [3:0] S_DEC    = 4'd1;
   localparam logic [3:0] S_APPRD  = 4'd2;
   localparam logic [3:0] S_TICKRD = 4'd3;
   localparam logic [3:0] S_TICKWR = 4'd4;
   localparam logic [3:0] S_LVL    = 4'd5;
   localparam logic [3:0] S_RD     = 4'd6;
   localparam logic [3:0] S_CHK    = 4'd7;
   localparam logic [3:0] S_RLVL   = 4'd8;
   localparam logic [3:0] S_RRD    = 4'd9;
   localparam logic [3:0] S_RCHK   = 4'd10;
   localparam logic [3:0] S_FIN    = 4'd11;
   localparam logic [3:0] S_APPEND = 4'd12;
   localparam logic [3:0] S_OUT    = 4'd13;

   // slot memories: level/budget/link, registered read
   logic [LW-1:0] lvl_mem  [NUM_TASKS];
   logic [BW-1:0] bud_mem  [NUM_TASKS];
   logic [TW-1:0] link_mem [NUM_TASKS];
   logic [LW-1:0] lvl_q;
   logic [BW-1:0] bud_q;
   logic [TW-1:0] link_q;

   // small per-slot and per-level control state
   logic [1:0]    state_ff [NUM_TASKS];
   logic          hv_ff    [NUM_LEVELS];
   logic [TW-1:0] head_ff  [NUM_LEVELS];
   logic [TW-1:0] tail_ff  [NUM_LEVELS];
   logic          cur_v_ff;
   logic [TW-1:0] cur_ff;

   logic [pbs_pkg::SCALE_W-1:0] scale_ff;
   logic [pbs_pkg::BASE_W-1:0]  base_ff;

   logic [3:0]    fsm_ff, fsm_in;
   logic [pbs_pkg::MODE_W-1:0]  mode_ff;
   logic [pbs_pkg::ID_W-1:0]    id_ff;
   logic [LW-1:0]               lvlin_ff;
   logic [BW-1:0]               budin_ff;
   logic [LW-1:0] l_ff;          // level under walk
   logic [TW-1:0] p_ff;          // slot under walk
   logic          pv_ff;         // predecessor valid
   logic [TW-1:0] pr_ff;
   logic          pass2_ff;      // second pick after refill
   logic          refill_ff;
   logic          found_ff;
   logic [TW-1:0] t_ff;
   logic [TW-1:0] app_ff;        // slot to append
   logic [pbs_pkg::STAT_W-1:0] stat_ff;
   logic [TW:0]   steps_ff;

   // memory port controls
   logic          rd_en;
   logic [TW-1:0] rd_addr;
   logic          bud_we;
   logic [TW-1:0] bud_wa;
   logic [BW-1:0] bud_wd;
   logic          link_we;
   logic [TW-1:0] link_wa;
   logic [TW-1:0] link_wd;
   logic          lvl_we;

   // old tail link of an append, written in the response cycle
   logic [TW-1:0] tail_link_addr;
   logic          tail_link_we_ff;

   always_ff @(posedge clock) begin
      if (rd_en) begin
         lvl_q  <= lvl_mem[rd_addr];
         bud_q  <= bud_mem[rd_addr];
         link_q <= link_mem[rd_addr];
      end
      if (bud_we)  bud_mem[bud_wa]   <= bud_wd;
      if (link_we) link_mem[link_wa] <= link_wd;
      if (lvl_we)  lvl_mem[id_ff[TW-1:0]] <= lvlin_ff;
   end

   // refill value for the level under walk, saturated
   logic [SW-1:0] refill_sum;
   logic [BW-1:0] refill_val;
   assign refill_sum = SW'(l_ff) * SW'(scale_ff) + SW'(base_ff);
   assign refill_val = (refill_sum > SW'(BMAX)) ? BMAX : refill_sum[BW-1:0];

   logic id_ff_ok;
   assign id_ff_ok = (32'(id_ff) < NUM_TASKS);

   assign req_stall = (fsm_ff != S_IDLE);
   assign rsp_valid = (fsm_ff == S_OUT);
   assign csr_ready = (fsm_ff == S_IDLE);
   assign rsp_running_valid = cur_v_ff;
   assign rsp_running_id    = cur_v_ff ? pbs_pkg::ID_W'(cur_ff) : '0;
   assign rsp_status        = stat_ff;
   assign rsp_refilled      = refill_ff;

   // memory control, combinational from sequencer state
   always_comb begin
      rd_en   = 1'b0;
      rd_addr = p_ff;
      bud_we  = 1'b0;
      bud_wa  = p_ff;
      bud_wd  = refill_val;
      link_we = 1'b0;
      link_wa = app_ff;
      link_wd = '0;
      lvl_we  = 1'b0;
      case (fsm_ff)
         S_DEC: begin
            if (mode_ff == pbs_pkg::MODE_ADMIT && id_ff_ok &&
                state_ff[id_ff[TW-1:0]] == pbs_pkg::ST_FREE) begin
               lvl_we = 1'b1;
               bud_we = 1'b1;
               bud_wa = id_ff[TW-1:0];
               bud_wd = budin_ff;
            end
         end
         S_APPRD: begin
            rd_en   = 1'b1;
            rd_addr = app_ff;
         end
         S_TICKRD: begin
            rd_en   = 1'b1;
            rd_addr = cur_ff;
         end
         S_TICKWR: begin
            bud_we = (bud_q != '0);
            bud_wa = cur_ff;
            bud_wd = bud_q - BW'(1);
         end
         S_RD, S_RRD: rd_en = 1'b1;
         S_RCHK: bud_we = 1'b1;
         S_FIN: begin
            if (found_ff && pv_ff) begin
               link_we = 1'b1;
               link_wa = pr_ff;
               link_wd = (t_ff == tail_ff[l_ff]) ? '0 : link_q;
            end
         end
         S_APPEND: begin
            link_we = 1'b1;
            link_wa = app_ff;
            link_wd = '0;
         end
         S_OUT: begin
            // old tail now points at the appended slot
            if (tail_link_we_ff) begin
               link_we = 1'b1;
               link_wa = tail_link_addr;
               link_wd = app_ff;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fsm_ff    <= S_IDLE;
         cur_v_ff  <= 1'b0;
         scale_ff  <= pbs_pkg::CSR_SCALE_RST;
         base_ff   <= pbs_pkg::CSR_BASE_RST;
         tail_link_we_ff <= 1'b0;
         for (int i = 0; i < NUM_TASKS; i++) state_ff[i] <= pbs_pkg::ST_FREE;
         for (int i = 0; i < NUM_LEVELS; i++) hv_ff[i] <= 1'b0;
      end else begin
         fsm_ff <= fsm_in;
         tail_link_we_ff <= 1'b0;
         if (csr_valid && csr_ready) begin
            if (csr_index == pbs_pkg::CSR_IDX_SCALE)
               scale_ff <= csr_data[pbs_pkg::SCALE_W-1:0];
            else
               base_ff <= csr_data[pbs_pkg::BASE_W-1:0];
         end
         case (fsm_ff)
            S_IDLE: begin
               if (req_valid) begin
                  mode_ff   <= req_mode;
                  id_ff     <= req_task_id;
                  lvlin_ff  <= (32'(req_task_level) < NUM_LEVELS) ?
                               LW'(req_task_level) : LW'(NUM_LEVELS - 1);
                  budin_ff  <= (32'(req_task_budget) > 32'(BMAX)) ?
                               BMAX : BW'(req_task_budget);
                  stat_ff   <= pbs_pkg::STAT_OK;
                  refill_ff <= 1'b0;
                  pass2_ff  <= 1'b0;
                  found_ff  <= 1'b0;
                  app_ff    <= TW'(req_task_id);
               end
            end
            S_DEC: begin
               case (mode_ff)
                  pbs_pkg::MODE_ADMIT, pbs_pkg::MODE_WAKE: begin
                     if (!id_ff_ok || state_ff[id_ff[TW-1:0]] !=
                         ((mode_ff == pbs_pkg::MODE_ADMIT) ?
                          pbs_pkg::ST_FREE : pbs_pkg::ST_WAITING))
                        stat_ff <= pbs_pkg::STAT_ILLEGAL;
                     else
                        state_ff[id_ff[TW-1:0]] <= pbs_pkg::ST_READY;
                  end
                  pbs_pkg::MODE_YIELD, pbs_pkg::MODE_BLOCK: begin
                     if (mode_ff == pbs_pkg::MODE_BLOCK && !cur_v_ff)
                        stat_ff <= pbs_pkg::STAT_ILLEGAL;
                     l_ff <= LW'(NUM_LEVELS - 1);
                  end
                  default: ;
               endcase
            end
            S_LVL: begin
               p_ff     <= head_ff[l_ff];
               pv_ff    <= 1'b0;
               steps_ff <= '0;
               // empty level: step down, or to the top for the refill pass
               if (!hv_ff[l_ff]) begin
                  if (l_ff != '0) l_ff <= l_ff - LW'(1);
                  else if (!pass2_ff) l_ff <= LW'(NUM_LEVELS - 1);
               end
            end
            S_CHK: begin
               if (bud_q != '0) begin
                  found_ff <= 1'b1;
                  t_ff     <= p_ff;
               end else if (p_ff == tail_ff[l_ff] ||
                            32'(steps_ff) + 1 >= NUM_TASKS) begin
                  if (l_ff != '0) l_ff <= l_ff - LW'(1);
                  else l_ff <= LW'(NUM_LEVELS - 1);
               end else begin
                  pv_ff    <= 1'b1;
                  pr_ff    <= p_ff;
                  p_ff     <= link_q;
                  steps_ff <= steps_ff + 1'b1;
               end
            end
            S_RLVL: begin
               p_ff     <= head_ff[l_ff];
               steps_ff <= '0;
               if (!hv_ff[l_ff]) begin
                  if (l_ff != '0) l_ff <= l_ff - LW'(1);
                  else begin
                     l_ff     <= LW'(NUM_LEVELS - 1);
                     pass2_ff <= 1'b1;
                  end
               end
            end
            S_RCHK: begin
               refill_ff <= 1'b1;
               if (p_ff == tail_ff[l_ff] || 32'(steps_ff) + 1 >= NUM_TASKS) begin
                  if (l_ff != '0) l_ff <= l_ff - LW'(1);
                  else begin
                     l_ff     <= LW'(NUM_LEVELS - 1);
                     pass2_ff <= 1'b1;
                  end
               end else begin
                  p_ff     <= link_q;
                  steps_ff <= steps_ff + 1'b1;
               end
            end
            S_FIN: begin
               if (!found_ff) begin
                  stat_ff <= pbs_pkg::STAT_NONE;
                  if (mode_ff == pbs_pkg::MODE_BLOCK) begin
                     state_ff[cur_ff] <= pbs_pkg::ST_WAITING;
                     cur_v_ff <= 1'b0;
                  end
               end else begin
                  // unlink the picked slot
                  if (!pv_ff) begin
                     if (t_ff == tail_ff[l_ff]) hv_ff[l_ff] <= 1'b0;
                     else head_ff[l_ff] <= link_q;
                  end
                  if (t_ff == tail_ff[l_ff])
                     tail_ff[l_ff] <= pv_ff ? pr_ff : '0;
                  if (cur_v_ff) begin
                     if (mode_ff == pbs_pkg::MODE_BLOCK)
                        state_ff[cur_ff] <= pbs_pkg::ST_WAITING;
                     else
                        state_ff[cur_ff] <= pbs_pkg::ST_READY;
                  end
                  app_ff   <= cur_ff;
                  state_ff[t_ff] <= pbs_pkg::ST_RUNNING;
                  cur_ff   <= t_ff;
                  cur_v_ff <= 1'b1;
               end
            end
            S_APPEND: begin
               // lvl_q holds the level of app_ff
               if (!hv_ff[lvl_q]) begin
                  hv_ff[lvl_q]   <= 1'b1;
                  head_ff[lvl_q] <= app_ff;
               end else begin
                  tail_link_we_ff <= 1'b1;
               end
               tail_link_addr <= tail_ff[lvl_q];
               tail_ff[lvl_q] <= app_ff;
            end
            default: ;
         endcase
      end
   end

   // sequencer next state, including the empty level skip
   always_comb begin
      fsm_in = fsm_ff;
      case (fsm_ff)
         S_IDLE:   if (req_valid) fsm_in = S_DEC;
         S_DEC: begin
            case (mode_ff)
               pbs_pkg::MODE_ADMIT, pbs_pkg::MODE_WAKE:
                  fsm_in = (!id_ff_ok || state_ff[id_ff[TW-1:0]] !=
                            ((mode_ff == pbs_pkg::MODE_ADMIT) ?
                             pbs_pkg::ST_FREE : pbs_pkg::ST_WAITING)) ?
                           S_OUT : S_APPRD;
               pbs_pkg::MODE_YIELD:  fsm_in = S_LVL;
               pbs_pkg::MODE_BLOCK:  fsm_in = cur_v_ff ? S_LVL : S_OUT;
               pbs_pkg::MODE_TICK:   fsm_in = cur_v_ff ? S_TICKRD : S_OUT;
               default:              fsm_in = S_OUT;
            endcase
         end
         S_APPRD:  fsm_in = S_APPEND;
         S_TICKRD: fsm_in = S_TICKWR;
         S_TICKWR: fsm_in = S_OUT;
         S_LVL: begin
            if (hv_ff[l_ff]) fsm_in = S_RD;
            else if (l_ff != '0) fsm_in = S_LVL;
            else fsm_in = pass2_ff ? S_FIN : S_RLVL;
         end
         S_RD:  fsm_in = S_CHK;
         S_CHK: begin
            if (bud_q != '0) fsm_in = S_FIN;
            else if (p_ff == tail_ff[l_ff] || 32'(steps_ff) + 1 >= NUM_TASKS)
               fsm_in = (l_ff != '0) ? S_LVL : (pass2_ff ? S_FIN : S_RLVL);
            else fsm_in = S_RD;
         end
         S_RLVL: fsm_in = hv_ff[l_ff] ? S_RRD :
                          ((l_ff != '0) ? S_RLVL : S_LVL);
         S_RRD:  fsm_in = S_RCHK;
         S_RCHK: begin
            if (p_ff == tail_ff[l_ff] || 32'(steps_ff) + 1 >= NUM_TASKS)
               fsm_in = (l_ff != '0) ? S_RLVL : S_LVL;
            else fsm_in = S_RRD;
         end
         S_FIN: fsm_in = (found_ff && cur_v_ff &&
                          mode_ff == pbs_pkg::MODE_YIELD) ? S_APPRD : S_OUT;
         S_APPEND: fsm_in = S_OUT;
         S_OUT: if (!rsp_stall) fsm_in = S_IDLE;
         default: fsm_in = S_IDLE;
      endcase
   end

`ifndef SYNTHESIS
   a_stall_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall)
      else $error("response shown while idle");
   a_one_rsp: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_stall) |=> !rsp_valid)
      else $error("response repeated");
   a_run_state: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_running_valid) |-> state_ff[cur_ff] == pbs_pkg::ST_RUNNING)
      else $error("running slot not in running state");
`endif

endmodule
